// ===== design/hill_pkg.sv =====
// hill_pkg: shared types, constants and mod-26 helpers for the 3x3 Hill cipher.
// No dependencies; used by every module under design/.
package hill_pkg;

    localparam int LETTER_W   = 5;
    localparam int KEY_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [LETTER_W-1:0] MOD_LETTERS = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER  = 5'd23;
    // 26*26, keeps a*b - c*d non-negative
    localparam logic [11:0]         MOD_SQUARE  = 12'd676;
    // ceil(2^16 / 26): exact quotient for any 12-bit dividend
    localparam logic [23:0]         MOD_RECIP   = 24'd2521;
    // busy-counter load on reset and key or mode writes while coefficients settle
    localparam logic [2:0]          INV_LAT     = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROW_ZERO = 3'd0,
        CFG_KEY_ROW_ONE  = 3'd1,
        CFG_KEY_ROW_TWO  = 3'd2,
        CFG_DECRYPT_MODE = 3'd3
    } t_cfg_idx;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef t_letter [2:0]       t_block;   // [0] is the first letter
    typedef t_letter [2:0][2:0]  t_mat;     // [row][col]

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_letter mod26(input logic [11:0] x);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [11:0] rem;
        prod = {12'd0, x} * MOD_RECIP;
        quot = prod[23:16];
        rem  = x - ({4'd0, quot} * 12'd26);
        return rem[LETTER_W-1:0];
    endfunction

    function automatic t_letter reduce26(input t_letter v);
        return (v >= MOD_LETTERS) ? v - MOD_LETTERS : v;
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic t_letter inv26(input t_letter d);
        t_letter r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/hill_front.sv =====
// hill_front: gathers accepted letters into blocks of three, pads a short final block.
// Depends on hill_pkg.
module hill_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  hill_pkg::t_letter i_letter,
    input  logic             i_final,
    output logic             o_push,
    output hill_pkg::t_block o_block
);

    logic [1:0]              r_fill;
    hill_pkg::t_letter [1:0] r_buf;

    always_comb begin
        o_push = i_accept && ((r_fill == 2'd2) || i_final);
        o_block[0] = (r_fill == 2'd0) ? i_letter : r_buf[0];
        case (r_fill)
            2'd0:    o_block[1] = hill_pkg::PAD_LETTER;
            2'd1:    o_block[1] = i_letter;
            default: o_block[1] = r_buf[1];
        endcase
        o_block[2] = (r_fill == 2'd2) ? i_letter : hill_pkg::PAD_LETTER;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_accept) begin
            r_fill <= o_push ? 2'd0 : r_fill + 2'd1;
        end
    end

    // fill is 0 or 1 whenever a letter is parked
    always_ff @(posedge i_clk) begin
        if (i_accept && !o_push) begin
            r_buf[r_fill[0]] <= i_letter;
        end
    end

endmodule

// ===== design/hill_fifo.sv =====
// hill_fifo: short block queue between the letter front end and the matrix unit.
// Depends on hill_pkg.
module hill_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hill_pkg::t_block  i_block,
    input  logic              i_pop,
    output hill_pkg::t_block  o_head,
    output hill_pkg::t_q_stat o_stat
);

    hill_pkg::t_block [hill_pkg::FIFO_DEPTH-1:0] r_mem;
    logic [hill_pkg::FIFO_PTR_W-1:0]             r_wr_ptr;
    logic [hill_pkg::FIFO_PTR_W-1:0]             r_rd_ptr;
    logic [hill_pkg::FIFO_CNT_W-1:0]             r_count;

    localparam logic [hill_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        hill_pkg::FIFO_PTR_W'(hill_pkg::FIFO_DEPTH - 1);
    localparam logic [hill_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        hill_pkg::FIFO_CNT_W'(hill_pkg::FIFO_DEPTH);

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_block;
        end
    end

endmodule

// ===== design/hill_inv.sv =====
// hill_inv: configuration registers and the pipelined mod-26 key inverse.
// Depends on hill_pkg; drives the coefficient matrix used by hill_back.
module hill_inv (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [hill_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hill_pkg::KEY_W-1:0]         i_cfg_data,
    output hill_pkg::t_mat                     o_coef,
    output logic                               o_busy
);

    logic [2:0][hill_pkg::KEY_W-1:0] r_key;
    logic                            r_mode;
    logic [2:0]                      r_busy_cnt;

    logic [2:0][2:0][9:0] r_prod_a;
    logic [2:0][2:0][9:0] r_prod_b;
    hill_pkg::t_mat       r_adj;      // [row][col] of the adjugate
    logic [2:0][9:0]      r_det_prod;
    hill_pkg::t_letter    r_det;
    logic [2:0][2:0][9:0] r_inv_prod;
    hill_pkg::t_mat       r_inv;
    hill_pkg::t_mat       r_coef;

    hill_pkg::t_mat       w_key;
    logic [2:0][2:0][9:0] n_prod_a;
    logic [2:0][2:0][9:0] n_prod_b;
    logic                 w_cfg_hit;

    assign o_coef = r_coef;
    assign o_busy = (r_busy_cnt != 3'd0);

    always_comb begin
        w_cfg_hit = 1'b0;
        case (i_cfg_index)
            hill_pkg::CFG_KEY_ROW_ZERO,
            hill_pkg::CFG_KEY_ROW_ONE,
            hill_pkg::CFG_KEY_ROW_TWO,
            hill_pkg::CFG_DECRYPT_MODE: w_cfg_hit = i_cfg_wr_en;
            default:                    w_cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_key[r][c] = hill_pkg::reduce26(r_key[r][c*5 +: 5]);
            end
        end
    end

    // cofactor products; adj[j][i] = k[i1][j1]*k[i2][j2] - k[i1][j2]*k[i2][j1]
    always_comb begin
        int i1;
        int i2;
        int j1;
        int j2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                i1 = (i == 2) ? 0 : i + 1;
                i2 = (i == 0) ? 2 : i - 1;
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                n_prod_a[j][i] = {5'd0, w_key[i1][j1]} * {5'd0, w_key[i2][j2]};
                n_prod_b[j][i] = {5'd0, w_key[i1][j2]} * {5'd0, w_key[i2][j1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_mode     <= 1'b0;
            r_busy_cnt <= hill_pkg::INV_LAT;   // flush the pipeline after reset
            r_inv      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    hill_pkg::CFG_KEY_ROW_ZERO: r_key[0] <= i_cfg_data;
                    hill_pkg::CFG_KEY_ROW_ONE:  r_key[1] <= i_cfg_data;
                    hill_pkg::CFG_KEY_ROW_TWO:  r_key[2] <= i_cfg_data;
                    hill_pkg::CFG_DECRYPT_MODE: r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_busy_cnt <= hill_pkg::INV_LAT;
            end else if (r_busy_cnt != 3'd0) begin
                r_busy_cnt <= r_busy_cnt - 3'd1;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_inv[r][c] <= hill_pkg::mod26({2'd0, r_inv_prod[r][c]});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_adj[r][c] <= hill_pkg::mod26({2'd0, r_prod_a[r][c]}
                                               + hill_pkg::MOD_SQUARE
                                               - {2'd0, r_prod_b[r][c]});
                r_inv_prod[r][c] <= {5'd0, hill_pkg::inv26(r_det)} * {5'd0, r_adj[r][c]};
            end
            r_det_prod[r] <= {5'd0, w_key[0][r]} * {5'd0, r_adj[r][0]};
        end
        r_det  <= hill_pkg::mod26({2'd0, r_det_prod[0]} + {2'd0, r_det_prod[1]}
                                  + {2'd0, r_det_prod[2]});
        r_coef <= r_mode ? r_inv : w_key;
    end

endmodule

// ===== design/hill_back.sv =====
// hill_back: takes blocks from the queue and emits one matrix row product per cycle
// unless stalled. Depends on hill_pkg; coefficients come from hill_inv.
module hill_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hill_pkg::t_block  i_head,
    input  hill_pkg::t_q_stat i_stat,
    input  hill_pkg::t_mat    i_coef,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output hill_pkg::t_letter o_letter,
    output logic              o_last
);

    logic [1:0]           r_row;
    logic                 r_a_valid;
    logic                 r_a_last;
    logic [2:0][9:0]      r_a_prod;
    logic                 r_out_valid;
    hill_pkg::t_letter    r_out_letter;
    logic                 r_out_last;

    hill_pkg::t_letter [2:0] w_row;
    logic                 w_out_adv;
    logic                 w_a_adv;
    logic                 w_take;

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_a_adv   = !r_a_valid || w_out_adv;
    assign w_take    = w_a_adv && !i_stat.empty;
    assign o_pop     = w_take && (r_row == 2'd2);

    assign o_valid  = r_out_valid;
    assign o_letter = r_out_letter;
    assign o_last   = r_out_last;

    always_comb begin
        case (r_row)
            2'd0:    w_row = i_coef[0];
            2'd1:    w_row = i_coef[1];
            default: w_row = i_coef[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= 2'd0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_adv) begin
                r_a_valid <= !i_stat.empty;
            end
            if (w_take) begin
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            if (w_out_adv) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int j = 0; j < 3; j++) begin
                r_a_prod[j] <= {5'd0, w_row[j]} * {5'd0, i_head[j]};
            end
            r_a_last <= (r_row == 2'd2);
        end
        if (w_out_adv && r_a_valid) begin
            r_out_letter <= hill_pkg::mod26({2'd0, r_a_prod[0]} + {2'd0, r_a_prod[1]}
                                            + {2'd0, r_a_prod[2]});
            r_out_last   <= r_a_last;
        end
    end

endmodule

// ===== design/hill_cipher_3x3_mod26.sv =====
// hill_cipher_3x3_mod26: top level of the letter-serial 3x3 Hill cipher, mod 26.
// Depends on hill_pkg, hill_front, hill_fifo, hill_back and hill_inv.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------
//  letter in | i_in_valid / o_in_ready    | i_letter_in, i_final_letter
//  letter out| o_out_valid / i_out_ready  | o_letter_out, o_block_last
//  config    | i_cfg_wr_en (no wait)      | i_cfg_index, i_cfg_data
//
// One letter in per cycle while o_in_ready is high; each block gives three letters out,
// one per cycle while i_out_ready is high, so the matrix unit keeps up with a full-rate
// stream. A completed block goes through the queue, the product register and the output
// register before its first letter shows. Reset is synchronous, active low; after reset
// and after a key-row or mode write, input stalls while the inverse pipeline settles.
// A stalled output fills the two-block queue, then the input stalls.
module hill_cipher_3x3_mod26 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [hill_pkg::LETTER_W-1:0]  i_letter_in,
    input  logic                           i_final_letter,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hill_pkg::LETTER_W-1:0]  o_letter_out,
    output logic                           o_block_last,
    input  logic                           i_cfg_wr_en,
    input  logic [hill_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hill_pkg::KEY_W-1:0]     i_cfg_data
);

    logic              w_accept;
    logic              w_push;
    logic              w_pop;
    logic              w_busy;
    hill_pkg::t_block  w_block;
    hill_pkg::t_block  w_head;
    hill_pkg::t_q_stat w_q_stat;
    hill_pkg::t_mat    w_coef;

    assign o_in_ready = !w_busy && !w_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    hill_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_letter (i_letter_in),
        .i_final  (i_final_letter),
        .o_push   (w_push),
        .o_block  (w_block)
    );

    hill_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_block (w_block),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    hill_inv u_inv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef),
        .o_busy      (w_busy)
    );

    hill_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_stat   (w_q_stat),
        .i_coef   (w_coef),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_letter (o_letter_out),
        .o_last   (o_block_last)
    );

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_index == hill_pkg::CFG_KEY_ROW_ZERO
                         || i_cfg_index == hill_pkg::CFG_KEY_ROW_ONE
                         || i_cfg_index == hill_pkg::CFG_KEY_ROW_TWO
                         || i_cfg_index == hill_pkg::CFG_DECRYPT_MODE))
        |=> !o_in_ready)
        else $error("request accepted while key inverse still settling");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("block pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_stat.empty))
        else $error("block popped from empty queue");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_letter_out < hill_pkg::MOD_LETTERS))
        else $error("output letter out of range");

endmodule

// ===== tb/sv/hill_cipher_3x3_mod26_check.sv =====
`timescale 1ns / 1ps
// hill_cipher_3x3_mod26_check: watches the letter channels and the register port, predicts
// every cipher letter from its own copy of key, mode and block state, and compares.
// Depends on hill_pkg for widths, the pad letter and the register indexes.
module hill_cipher_3x3_mod26_check
    import hill_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_letter              i_letter_in,
    input  logic                 i_final_letter,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_letter              i_letter_out,
    input  logic                 i_block_last,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_letters_left,
    output int                   o_letters_checked
);

    localparam int RADIX = int'(MOD_LETTERS);

    typedef struct packed {
        t_letter letter;
        logic    last;
    } t_cipher_letter;

    logic [KEY_W-1:0] key_rows [3];
    logic             decrypt;
    t_letter          block_held [3];
    int               held_count;
    t_mat             inverse_key;
    t_cipher_letter   cipher_q [$];

    int mismatches = 0;
    int checked    = 0;
    int left_count = 0;

    assign o_fail_count      = mismatches;
    assign o_letters_left    = left_count;
    assign o_letters_checked = checked;

    function automatic int key_digit(input int row, input int col);
        return int'(key_rows[row][col*LETTER_W +: LETTER_W]) % RADIX;
    endfunction

    // adjugate times inverse determinant; all zero when the determinant has no inverse
    function automatic void rebuild_inverse();
        int adj [3][3];
        int det;
        int inv;
        det = 0;
        inv = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                adj[j][i] = (key_digit((i + 1) % 3, (j + 1) % 3) * key_digit((i + 2) % 3, (j + 2) % 3)
                             + RADIX * RADIX
                             - key_digit((i + 1) % 3, (j + 2) % 3) * key_digit((i + 2) % 3, (j + 1) % 3))
                            % RADIX;
            end
        end
        for (int i = 0; i < 3; i++) begin
            det = (det + key_digit(0, i) * adj[i][0]) % RADIX;
        end
        for (int d = 1; d < RADIX; d++) begin
            if (inv == 0 && (det * d) % RADIX == 1) inv = d;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                inverse_key[i][j] = t_letter'((inv * adj[i][j]) % RADIX);
            end
        end
    endfunction

    function automatic void take_letter(input t_letter letter, input logic fin);
        int acc;
        int m;
        block_held[held_count] = letter;
        held_count++;
        if (held_count < 3 && !fin) return;
        while (held_count < 3) begin
            block_held[held_count] = PAD_LETTER;
            held_count++;
        end
        held_count = 0;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                m = decrypt ? int'(inverse_key[i][j]) : key_digit(i, j);
                acc += m * int'(block_held[j]);
            end
            cipher_q.push_back(t_cipher_letter'{letter: t_letter'(acc % RADIX), last: (i == 2)});
        end
    endfunction

    function automatic void check_letter(input t_letter got_letter, input logic got_last);
        t_cipher_letter want;
        if (cipher_q.size() == 0) begin
            if (mismatches < 10)
                $display("[%0t] cipher letter %0d last %0b with none expected",
                         $time, got_letter, got_last);
            mismatches++;
            return;
        end
        want = cipher_q.pop_front();
        checked++;
        if (got_letter !== want.letter || got_last !== want.last) begin
            if (mismatches < 10)
                $display("[%0t] cipher letter mismatch: expected %0d last %0b, got %0d last %0b",
                         $time, want.letter, want.last, got_letter, got_last);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_rows   = '{default: '0};
            decrypt    = 1'b0;
            held_count = 0;
            cipher_q.delete();
            rebuild_inverse();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_KEY_ROW_ZERO, CFG_KEY_ROW_ONE, CFG_KEY_ROW_TWO: begin
                        key_rows[i_cfg_index] = i_cfg_data;
                        rebuild_inverse();
                    end
                    CFG_DECRYPT_MODE: begin
                        decrypt = i_cfg_data[0];
                        rebuild_inverse();
                    end
                    default: ; // indexes past the mode register do nothing
                endcase
            end
            if (i_in_valid && i_in_ready) take_letter(i_letter_in, i_final_letter);
            if (i_out_valid && i_out_ready) check_letter(i_letter_out, i_block_last);
        end
        left_count <= cipher_q.size();
    end

endmodule

// ===== tb/sv/hill_cipher_3x3_mod26_test.sv =====
`timescale 1ns / 1ps
// hill_cipher_3x3_mod26_test: top of the testbench; drives letters, register writes and
// output back-pressure into the cipher and reports the verdict.
// Depends on hill_pkg, hill_cipher_3x3_mod26 and hill_cipher_3x3_mod26_check.
module hill_cipher_3x3_mod26_test;
    import hill_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASES         = 8;
    localparam int PHASE_LETTERS  = 40;
    localparam int PRESSURE_PHASE = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    t_letter              letter_in    = '0;
    logic                 final_letter = 1'b0;
    logic                 out_ready    = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [KEY_W-1:0]     cfg_data     = '0;
    logic                 in_ready;
    logic                 out_valid;
    t_letter              letter_out;
    logic                 block_last;

    int fail_count;
    int letters_left;
    int letters_checked;

    bit calm          = 1'b0;
    bit pressure_on   = 1'b0;
    bit pressure_done = 1'b0;
    int pause_odds    = 0;
    int msg_left      = 0;
    int letters_sent  = 0;
    int reg_writes    = 0;

    hill_cipher_3x3_mod26 uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_letter_in    (letter_in),
        .i_final_letter (final_letter),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_letter_out   (letter_out),
        .o_block_last   (block_last),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    hill_cipher_3x3_mod26_check u_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_letter_in       (letter_in),
        .i_final_letter    (final_letter),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_letter_out      (letter_out),
        .i_block_last      (block_last),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_letters_left    (letters_left),
        .o_letters_checked (letters_checked)
    );

    always #2 clk = ~clk;

    function automatic logic [KEY_W-1:0] pack_row(input int e0, input int e1, input int e2);
        return {t_letter'(e2), t_letter'(e1), t_letter'(e0)};
    endfunction

    function automatic logic [KEY_W-1:0] random_row();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return pack_row($urandom_range(0, 25), $urandom_range(0, 25),
                                     $urandom_range(0, 25));
            default: return KEY_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // holds the request until the block takes it
    task automatic send_letter(input int letter, input logic fin);
        in_valid     <= 1'b1;
        letter_in    <= t_letter'(letter);
        final_letter <= fin;
        do @(posedge clk); while (!in_ready);
        letters_sent++;
    endtask

    task automatic sender_pause();
        if (pause_odds != 0 && $urandom_range(1, pause_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // drain all pending cipher letters, then let the front end go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (letters_left != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        // zero key after reset: every letter maps to A
        send_letter(0, 1'b0);
        send_letter(25, 1'b0);
        send_letter(31, 1'b0);
        settle();
        write_reg(CFG_KEY_ROW_ZERO, pack_row(6, 24, 1));
        write_reg(CFG_KEY_ROW_ONE,  pack_row(13, 16, 10));
        write_reg(CFG_KEY_ROW_TWO,  pack_row(20, 17, 15));
        write_reg(CFG_DECRYPT_MODE, 15'd0);
        send_letter(0, 1'b0);
        send_letter(2, 1'b0);
        send_letter(19, 1'b0);
        send_letter(25, 1'b1);      // one letter then two pads
        send_letter(31, 1'b0);
        send_letter(26, 1'b1);      // two letters then one pad
        settle();
        write_reg(CFG_DECRYPT_MODE, 15'd1);
        send_letter(15, 1'b0);
        send_letter(14, 1'b0);
        send_letter(7, 1'b0);
        send_letter(7, 1'b1);
        // key row rewritten while one letter is held
        send_letter(4, 1'b0);
        settle();
        write_reg(CFG_KEY_ROW_ONE, pack_row(25, 25, 0));
        write_reg(CFG_UNUSED_FIRST, '1);
        send_letter(9, 1'b0);
        send_letter(30, 1'b0);
        settle();
        // all-ones key is singular: decrypt gives A throughout
        write_reg(CFG_KEY_ROW_ZERO, '1);
        write_reg(CFG_KEY_ROW_ONE,  '1);
        write_reg(CFG_KEY_ROW_TWO,  '1);
        send_letter(1, 1'b0);
        send_letter(2, 1'b0);
        send_letter(3, 1'b1);       // final lands on a full block
        settle();
        write_reg(CFG_DECRYPT_MODE, 15'd0);
        write_reg(CFG_UNUSED_LAST, 15'h5555);
        send_letter(31, 1'b0);
        send_letter(31, 1'b0);
        send_letter(31, 1'b1);
        settle();
    endtask

    task automatic configure();
        logic [KEY_W-1:0] mode_word;
        mode_word = KEY_W'($urandom_range(0, 32767));
        if ($urandom_range(0, 1)) write_reg(CFG_DECRYPT_MODE, mode_word);
        write_reg(CFG_KEY_ROW_TWO, random_row());
        write_reg(CFG_KEY_ROW_ZERO, random_row());
        write_reg(CFG_KEY_ROW_ONE, random_row());
        if ($urandom_range(0, 3) == 0)
            write_reg(t_cfg_idx'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                      KEY_W'($urandom_range(0, 32767)));
        write_reg(CFG_DECRYPT_MODE, {mode_word[KEY_W-1:1], 1'($urandom_range(0, 1))});
    endtask

    task automatic run_phase();
        int letter;
        for (int k = 0; k < PHASE_LETTERS; k++) begin
            // messages may run over a phase boundary, so keys change mid-block too
            if (msg_left == 0) msg_left = $urandom_range(1, 10);
            msg_left--;
            letter = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
            send_letter(letter, msg_left == 0);
            sender_pause();
        end
    endtask

    // receiver: random stall bursts, one long hold, always ready near the end
    initial begin
        @(posedge clk);
        forever begin
            if (pressure_on && !pressure_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                pressure_done = 1'b1;
            end else if (calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d cipher letters outstanding",
                 CYCLE_LIMIT, letters_left);
        $display("hill_cipher_3x3_mod26_test NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            calm        = (phase == PHASES - 1);
            pressure_on = (phase == PRESSURE_PHASE);
            if (calm || pressure_on) pause_odds = 0;
            else pause_odds = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 8);
            configure();
            run_phase();
            settle();
        end
        $display("run: %0d letters in, %0d cipher letters checked, %0d register writes",
                 letters_sent, letters_checked, reg_writes);
        $display("covered encrypt and decrypt, singular keys, padded short blocks, mid-block key"
                 , " changes and a long output stall");
        if (fail_count == 0 && letters_left == 0) begin
            $display("hill_cipher_3x3_mod26_test OK");
        end else begin
            $display("hill_cipher_3x3_mod26_test NOT OK");
        end
        $finish;
    end

endmodule
